@@ hdl/bdq_pkg.sv @@
package bdq_pkg;

  localparam int BDQ_DEPTH = 16;

  localparam logic [3:0] ACT_PUSH_FRONT    = 4'd0;
  localparam logic [3:0] ACT_PUSH_BACK     = 4'd1;
  localparam logic [3:0] ACT_POP_FRONT     = 4'd2;
  localparam logic [3:0] ACT_POP_BACK      = 4'd3;
  localparam logic [3:0] ACT_PEEK_FRONT    = 4'd4;
  localparam logic [3:0] ACT_PEEK_BACK     = 4'd5;
  localparam logic [3:0] ACT_FIND_FIRST    = 4'd6;
  localparam logic [3:0] ACT_FIND_LAST     = 4'd7;
  localparam logic [3:0] ACT_INSERT_AFTER  = 4'd8;
  localparam logic [3:0] ACT_INSERT_BEFORE = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic        [3:0]  action;
    logic signed [31:0] value;
    logic        [4:0]  position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic        [4:0]  found_position;
    logic        [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_FAIL_EMPTY,
    OP_FAIL_FULL,
    OP_FAIL_MISS,
    OP_PUSH_BACK,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_PEEK_FRONT,
    OP_PEEK_BACK,
    OP_POP_BACK,
    OP_FIND_FWD,
    OP_FIND_BWD
  } op_t;

  typedef struct packed {
    logic load;
    logic run;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
    logic walk_end;
  } stat_t;

endpackage

@@ hdl/bdq_datapath.sv @@
module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::BDQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  bdq_pkg::req_t req,
  input  bdq_pkg::cmd_t cmd,
  output bdq_pkg::stat_t stat,
  output bdq_pkg::rsp_t rsp
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic        [CW-1:0] cnt;
  logic        [CW-1:0] ptr;
  logic        [CW-1:0] at;
  logic        [AW-1:0] tag;
  logic                 pend;
  logic                 first;
  op_t                  op_r;
  logic signed [31:0]   val;
  logic signed [31:0]   res_data;
  logic        [4:0]    res_pos;
  logic        [1:0]    res_status;

  logic                 issue;
  logic        [AW-1:0] raddr;
  logic                 we;
  logic        [AW-1:0] waddr;
  logic signed [31:0]   wdata;
  logic                 hit;
  logic                 walk_end;
  logic        [PW-1:0] pos_w;
  logic        [PW-1:0] cnt_w;

  assign pos_w = PW'(req.position);
  assign cnt_w = PW'(cnt);

  assign stat.full     = (cnt == CW'(DEPTH));
  assign stat.empty    = (cnt == '0);
  assign stat.pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign stat.walk_end = walk_end;

  assign rsp.data           = res_data;
  assign rsp.found_position = res_pos;
  assign rsp.status         = res_status;

  always_comb begin
    issue    = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata;
    hit      = 1'b0;
    walk_end = 1'b0;
    if (cmd.load && cmd.op == OP_PUSH_BACK) begin
      we    = 1'b1;
      waddr = AW'(cnt);
      wdata = req.value;
    end
    if (cmd.run) begin
      case (op_r)
        OP_SHIFT_UP: begin
          issue = (ptr > at);
          raddr = AW'(ptr - CW'(1));
          if (pend) begin
            we    = 1'b1;
            waddr = tag + AW'(1);
          end else if (!issue) begin
            // gap is open: drop the new value in
            we       = 1'b1;
            waddr    = AW'(at);
            wdata    = val;
            walk_end = 1'b1;
          end
        end
        OP_SHIFT_DOWN: begin
          issue = (ptr < cnt);
          raddr = AW'(ptr);
          if (pend && !first) begin
            we    = 1'b1;
            waddr = tag - AW'(1);
          end
          walk_end = !issue && !pend;
        end
        OP_FIND_FWD: begin
          issue    = (ptr < cnt);
          raddr    = AW'(ptr);
          hit      = pend && (rdata == val);
          walk_end = hit || (!issue && !pend);
        end
        OP_FIND_BWD: begin
          issue    = (ptr != '0);
          raddr    = AW'(ptr - CW'(1));
          hit      = pend && (rdata == val);
          walk_end = hit || (!issue && !pend);
        end
        OP_PEEK_FRONT, OP_PEEK_BACK, OP_POP_BACK: begin
          issue    = first;
          raddr    = AW'(ptr);
          walk_end = pend;
        end
        default: begin
          walk_end = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.load) begin
      op_r     <= cmd.op;
      val      <= req.value;
      pend     <= 1'b0;
      first    <= 1'b1;
      res_data <= '0;
      res_pos  <= '0;
      case (cmd.op)
        OP_FAIL_EMPTY:            res_status <= ST_EMPTY;
        OP_FAIL_FULL:             res_status <= ST_FULL;
        OP_FAIL_MISS:             res_status <= ST_MISS;
        OP_FIND_FWD, OP_FIND_BWD: res_status <= ST_MISS;
        default:                  res_status <= ST_OK;
      endcase
      case (cmd.op)
        OP_SHIFT_UP, OP_FIND_BWD: ptr <= cnt;
        OP_PEEK_BACK, OP_POP_BACK: ptr <= cnt - CW'(1);
        default:                  ptr <= '0;
      endcase
      case (req.action)
        ACT_INSERT_AFTER:  at <= CW'(req.position);
        ACT_INSERT_BEFORE: at <= CW'(req.position - 5'd1);
        default:           at <= '0;
      endcase
      if (cmd.op == OP_PUSH_BACK) begin
        cnt <= cnt + CW'(1);
      end
    end else if (cmd.run) begin
      pend <= issue;
      if (issue) begin
        tag <= raddr;
        if (op_r == OP_SHIFT_UP || op_r == OP_FIND_BWD) begin
          ptr <= ptr - CW'(1);
        end else begin
          ptr <= ptr + CW'(1);
        end
      end
      case (op_r)
        OP_SHIFT_UP: begin
          if (walk_end) cnt <= cnt + CW'(1);
        end
        OP_SHIFT_DOWN: begin
          if (pend && first) begin
            res_data <= rdata;
            first    <= 1'b0;
          end
          if (walk_end) cnt <= cnt - CW'(1);
        end
        OP_FIND_FWD, OP_FIND_BWD: begin
          if (hit) begin
            res_data   <= val;
            res_pos    <= 5'(int'(tag) + 1);
            res_status <= ST_OK;
          end
        end
        OP_PEEK_FRONT, OP_PEEK_BACK, OP_POP_BACK: begin
          if (issue) first <= 1'b0;
          if (pend) begin
            res_data <= rdata;
            if (op_r == OP_POP_BACK) cnt <= cnt - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end else begin
      pend <= 1'b0;
    end
  end

endmodule

@@ hdl/bdq_controller.sv @@
module bdq_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic [3:0]     action,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t  cmd
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op;

  always_comb begin
    case (action)
      ACT_PUSH_FRONT:    op = stat.full  ? OP_FAIL_FULL  : OP_SHIFT_UP;
      ACT_PUSH_BACK:     op = stat.full  ? OP_FAIL_FULL  : OP_PUSH_BACK;
      ACT_POP_FRONT:     op = stat.empty ? OP_FAIL_EMPTY : OP_SHIFT_DOWN;
      ACT_POP_BACK:      op = stat.empty ? OP_FAIL_EMPTY : OP_POP_BACK;
      ACT_PEEK_FRONT:    op = stat.empty ? OP_FAIL_EMPTY : OP_PEEK_FRONT;
      ACT_PEEK_BACK:     op = stat.empty ? OP_FAIL_EMPTY : OP_PEEK_BACK;
      ACT_FIND_FIRST:    op = OP_FIND_FWD;
      ACT_FIND_LAST:     op = OP_FIND_BWD;
      ACT_INSERT_AFTER, ACT_INSERT_BEFORE: begin
        if (stat.full) op = OP_FAIL_FULL;
        else if (!stat.pos_ok) op = OP_FAIL_MISS;
        else op = OP_SHIFT_UP;
      end
      default:           op = OP_FAIL_MISS;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign cmd.load  = req_valid && req_ready;
  assign cmd.run   = (state == S_WALK);
  assign cmd.op    = op;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          // failures and push at back finish in the accept cycle
          if (op inside {OP_FAIL_EMPTY, OP_FAIL_FULL, OP_FAIL_MISS, OP_PUSH_BACK}) begin
            state_next = S_RESP;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_end) state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/bounded_deque_with_search.sv @@
// Bounded deque with search: an ordered list of up to DEPTH signed 32-bit values.
// req channel (req_valid/req_ready/req) carries one action with value and position;
// rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per transaction.
// One transaction is handled at a time: req_ready is high only while idle.
// Push at back and every failed action answer without a walk through the list.
// Peek and pop at back read one entry; find reads entries from the front or the
// back until a match or the end of the list, and an empty list ends in a miss.
// Push at front and insert move every entry from the target slot up by one; pop
// at front moves every entry down by one. Each walk runs on the entry memory,
// which has one read and one write port and moves or compares one entry per cycle
// with a registered read. After rsp is taken the block is idle in the next cycle.
// At reset the list is empty; entry storage is not cleared.
// When the receiver stalls, rsp holds and no new transaction is accepted.
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::BDQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bdq_pkg::rsp_t rsp
);
  import bdq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bdq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .action    (req.action),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

@@ hdl/bdq_checker.sv @@
module bdq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bdq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bdq_pkg::rsp_t rsp
);
  import bdq_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transaction accepted while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while a result is pending");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |=> !rsp_valid)
    else $error("result repeated");

  a_pos_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found_position != 5'd0 |-> rsp.status == ST_OK)
    else $error("position reported on failure");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bdq_pkg::*;

  class deque_scoreboard;
    logic signed [31:0] slots[$];
    rsp_t               pending[$];
    int                 errors;
    int                 checked;

    function void note_request(req_t r);
      rsp_t e;
      int   n;
      int   i;
      n = slots.size();
      e = '0;
      e.status = ST_OK;
      case (r.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (n >= BDQ_DEPTH) e.status = ST_FULL;
          else if (r.action == ACT_PUSH_FRONT) slots.insert(0, r.value);
          else slots.insert(n, r.value);
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (n == 0) e.status = ST_EMPTY;
          else if (r.action == ACT_POP_FRONT) begin
            e.data = slots[0];
            slots.delete(0);
          end else begin
            e.data = slots[n-1];
            slots.delete(n - 1);
          end
        end
        ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
          if (n == 0) e.status = ST_EMPTY;
          else e.data = (r.action == ACT_PEEK_FRONT) ? slots[0] : slots[n-1];
        end
        ACT_FIND_FIRST: begin
          e.status = ST_MISS;
          for (i = 0; i < n; i++) begin
            if (slots[i] == r.value) begin
              e.data = r.value; e.found_position = 5'(i + 1); e.status = ST_OK;
              break;
            end
          end
        end
        ACT_FIND_LAST: begin
          e.status = ST_MISS;
          for (i = n - 1; i >= 0; i--) begin
            if (slots[i] == r.value) begin
              e.data = r.value; e.found_position = 5'(i + 1); e.status = ST_OK;
              break;
            end
          end
        end
        ACT_INSERT_AFTER, ACT_INSERT_BEFORE: begin
          if (n >= BDQ_DEPTH) e.status = ST_FULL;
          else if (r.position == 5'd0 || int'(r.position) > n) e.status = ST_MISS;
          else if (r.action == ACT_INSERT_AFTER) slots.insert(int'(r.position), r.value);
          else slots.insert(int'(r.position) - 1, r.value);
        end
        default: e.status = ST_MISS;
      endcase
      pending.insert(pending.size(), e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("response with nothing outstanding: %p", a);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (a.data !== e.data) begin
        $error("data: expected %0d, got %0d", e.data, a.data);
        errors++;
      end
      if (a.found_position !== e.found_position) begin
        $error("found_position: expected %0d, got %0d", e.found_position, a.found_position);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  deque_scoreboard sb;
  bit   idle_on = 1'b1;
  int   stall_cnt;
  int   quiet_cycles;
  int   sent;

  localparam int QUIET_LIMIT = 5000;

  always #5 clk = ~clk;

  bounded_deque_with_search u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // receiver: random stall bursts while idle_on is set, one check per transaction
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (stall_cnt > 0) begin
        stall_cnt--;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 5) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // valid stays up after an accept; the next call replaces the payload or drops valid
  task automatic send(logic [3:0] act, logic signed [31:0] val, logic [4:0] pos);
    req_t r;
    int   gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.action = act;
    r.value = val;
    r.position = pos;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (BDQ_DEPTH + 4) @(posedge clk);
  endtask

  // pick a value likely to hit a stored entry
  function automatic logic signed [31:0] pick_value();
    int n;
    n = sb.slots.size();
    if (n != 0 && $urandom_range(0, 2) != 0) return sb.slots[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    logic [3:0] act;
    logic [4:0] pos;
    int         n;
    n = sb.slots.size();
    if ($urandom_range(0, 49) == 0) act = 4'($urandom_range(10, 15));
    else if (n < 4 && $urandom_range(0, 1) == 0) act = 4'($urandom_range(0, 1));
    else if (n > 13 && $urandom_range(0, 1) == 0) act = 4'($urandom_range(2, 3));
    else act = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 7) == 0) pos = 5'($urandom);
    else pos = (n == 0) ? 5'd1 : 5'($urandom_range(1, n));
    send(act, pick_value(), pos);
  endtask

  initial begin
    int i;
    sb = new();
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty-list failures, including insert into an empty list, then pushes, inserts, finds and undefined actions
    send(ACT_POP_FRONT, 32'sd0, 5'd0);
    send(ACT_POP_BACK, 32'sd0, 5'd0);
    send(ACT_PEEK_FRONT, 32'sd0, 5'd0);
    send(ACT_PEEK_BACK, 32'sd0, 5'd0);
    send(ACT_FIND_FIRST, 32'sd0, 5'd0);
    send(ACT_FIND_LAST, 32'sd0, 5'd0);
    send(ACT_INSERT_AFTER, 32'sd5, 5'd1);
    send(ACT_PUSH_BACK, 32'sh7fff_ffff, 5'd0);
    send(ACT_PUSH_FRONT, 32'sh8000_0000, 5'd31);
    send(ACT_PUSH_BACK, 32'sh8000_0000, 5'd0);
    send(ACT_INSERT_BEFORE, 32'sd9, 5'd0);
    send(ACT_INSERT_AFTER, 32'sd9, 5'd4);
    send(ACT_INSERT_AFTER, 32'sd7, 5'd3);
    send(ACT_INSERT_BEFORE, -32'sd1, 5'd1);
    send(ACT_FIND_FIRST, 32'sh8000_0000, 5'd0);
    send(ACT_FIND_LAST, 32'sh8000_0000, 5'd0);
    send(ACT_FIND_LAST, 32'sd12345, 5'd0);
    send(4'd15, 32'sd1, 5'd0);
    send(4'd10, 32'sd1, 5'd0);
    // fill to capacity, then overflow on push and insert, then peek at back and pop at front
    while (sb.slots.size() < BDQ_DEPTH) send(ACT_PUSH_FRONT, $urandom, 5'd0);
    send(ACT_PUSH_BACK, 32'sd1, 5'd0);
    send(ACT_INSERT_BEFORE, 32'sd1, 5'd16);
    send(ACT_PEEK_BACK, 32'sd0, 5'd0);
    send(ACT_POP_FRONT, 32'sd0, 5'd0);

    // sender holds off until every response is back
    drain();

    for (i = 0; i < 410; i++) begin
      if (i == 350) begin
        drain();
        idle_on = 1'b0;
      end
      random_item();
    end

    drain();
    $display("Ran %0d transactions, %0d responses checked, on every action and fail path.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
